### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the SD SPI command engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SDC_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define SDC_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SDC_ASSERT_IMPL(lbl, clk, rst, a, c)
`define SDC_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

### sv/sdc_pkg.sv
// Types, constants and frame helpers of the SD SPI command engine.
`timescale 1ns / 1ps
package sdc_pkg;

  // Request op codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_RX    = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    REG_RESP_POLLS = 1'b0,
    REG_BUSY_POLLS = 1'b1
  } cfg_reg_t;

  // Command sequencing phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_APP_READY = 4'd1,
    PH_APP_FRAME = 4'd2,
    PH_APP_POLL  = 4'd3,
    PH_DESEL     = 4'd4,
    PH_READY     = 4'd5,
    PH_FRAME     = 4'd6,
    PH_STUFF     = 4'd7,
    PH_POLL      = 4'd8,
    PH_BUSY      = 4'd9,
    PH_R2        = 4'd10
  } phase_t;

  localparam int CmdW   = 6;
  localparam int ArgW   = 32;
  localparam int RespW  = 16;
  localparam int RPollW = 5;
  localparam int BPollW = 17;
  localparam int CfgW   = 17;

  localparam logic [CmdW-1:0] CMD_GO_IDLE = 6'd0;
  localparam logic [CmdW-1:0] CMD_IF_COND = 6'd8;
  localparam logic [CmdW-1:0] CMD_STOP    = 6'd12;
  localparam logic [CmdW-1:0] CMD_STATUS  = 6'd13;
  localparam logic [CmdW-1:0] CMD_ERASE   = 6'd38;
  localparam logic [CmdW-1:0] CMD_APP     = 6'd55;

  localparam logic [7:0] FRAME_START = 8'h40;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] CRC_DUMMY   = 8'hAA | 8'h01;
  localparam logic [7:0] CRC_APP     = 8'h55 | 8'h01;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] BUSY_BYTE   = 8'h00;
  localparam logic [7:0] R1_OK_MAX   = 8'h01;
  localparam logic [2:0] FRAME_LEN   = 3'd6;

  localparam logic [RPollW-1:0] RPOLL_MIN   = 5'd1;
  localparam logic [RPollW-1:0] RPOLL_MAX   = 5'd16;
  localparam logic [RPollW-1:0] RPOLL_RESET = 5'd9;
  localparam logic [BPollW-1:0] BPOLL_MIN   = 17'd1;
  localparam logic [BPollW-1:0] BPOLL_MAX   = 17'd65536;
  localparam logic [BPollW-1:0] BPOLL_RESET = 17'd65536;

  // One request item
  typedef struct packed {
    op_t             op;
    logic [CmdW-1:0] command_index;
    logic            app_command;
    logic [ArgW-1:0] argument;
    logic [7:0]      rx_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             chip_select_low;
    logic             done_res;
    logic [RespW-1:0] response;
  } result_t;

  // Sequencer state
  typedef struct packed {
    phase_t            phase;
    logic              sel;
    logic [2:0]        fcnt;
    logic [BPollW-1:0] pcnt;
    logic [CmdW-1:0]   cmd;
    logic              app;
    logic [ArgW-1:0]   arg;
    logic [RespW-1:0]  resp;
  } state_t;

  // Byte k of the main command frame
  function automatic logic [7:0] frame_byte(input logic [2:0] k,
                                            input logic [CmdW-1:0] cmd,
                                            input logic app,
                                            input logic [ArgW-1:0] arg);
    logic [7:0] b;
    case (k)
      3'd0: b = FRAME_START | {2'b00, cmd};
      3'd1: b = arg[31:24];
      3'd2: b = arg[23:16];
      3'd3: b = arg[15:8];
      3'd4: b = arg[7:0];
      default: begin
        if (!app && cmd == CMD_GO_IDLE) b = CRC_CMD0;
        else if (!app && cmd == CMD_IF_COND) b = CRC_CMD8;
        else b = CRC_DUMMY;
      end
    endcase
    return b;
  endfunction

  // Byte k of the CMD55 prefix frame
  function automatic logic [7:0] app_frame_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = FRAME_START | {2'b00, CMD_APP};
      3'd1, 3'd2, 3'd3, 3'd4: b = 8'h00;
      default: b = CRC_APP;
    endcase
    return b;
  endfunction

endpackage

### sv/sdc_req_if.sv
// Request channel: command starts and received card bytes.
`timescale 1ns / 1ps
interface sdc_req_if;
  logic                       valid;
  logic                       ready;
  sdc_pkg::op_t               op;
  logic [sdc_pkg::CmdW-1:0]   command_index;
  logic                       app_command;
  logic [sdc_pkg::ArgW-1:0]   argument;
  logic [7:0]                 rx_byte;

  modport source (output valid, op, command_index, app_command, argument, rx_byte,
                  input ready);
  modport sink   (input valid, op, command_index, app_command, argument, rx_byte,
                  output ready);
endinterface

### sv/sdc_rsp_if.sv
// Result channel: next SPI exchange or command completion.
`timescale 1ns / 1ps
interface sdc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      tx_valid;
  logic [7:0]                tx_byte;
  logic                      chip_select_low;
  logic                      done_res;
  logic [sdc_pkg::RespW-1:0] response;

  modport source (output valid, tx_valid, tx_byte, chip_select_low, done_res, response,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, chip_select_low, done_res, response,
                  output ready);
endinterface

### sv/sdc_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
interface sdc_cfg_if;
  logic                     valid;
  logic                     ready;
  sdc_pkg::cfg_reg_t        index;
  logic [sdc_pkg::CfgW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/sdc_step.sv
// Next-state and result logic for one request of the command sequencer.
`timescale 1ns / 1ps
module sdc_step (
  input  sdc_pkg::state_t                  st,
  input  sdc_pkg::item_t                   item,
  input  logic [sdc_pkg::RPollW-1:0]       rmax,
  input  logic [sdc_pkg::BPollW-1:0]       bmax,
  output sdc_pkg::state_t                  st_next,
  output sdc_pkg::result_t                 res
);

  always_comb begin
    sdc_pkg::state_t n;
    logic [2:0]      f;
    logic            tx_v;
    logic [7:0]      tx_b;
    logic            done;
    logic            go_main;
    logic            go_frame;
    logic            go_poll;
    logic            go_after;
    logic            go_fin;
    logic            poll_more;
    logic            busy_more;
    logic            busy_cmd;

    n         = st;
    tx_v      = 1'b0;
    tx_b      = sdc_pkg::IDLE_BYTE;
    done      = 1'b0;
    go_main   = 1'b0;
    go_frame  = 1'b0;
    go_poll   = 1'b0;
    go_after  = 1'b0;
    go_fin    = 1'b0;
    f         = st.fcnt + 3'd1;
    poll_more = item.rx_byte[7] && (st.pcnt < {12'd0, rmax});
    busy_more = (item.rx_byte == sdc_pkg::BUSY_BYTE) && (st.pcnt < bmax);
    busy_cmd  = !st.app && (st.cmd == sdc_pkg::CMD_STOP || st.cmd == sdc_pkg::CMD_ERASE);

    if (item.op == sdc_pkg::OP_START) begin
      // Latch a new command; aborts anything in flight
      n.cmd  = item.command_index;
      n.app  = item.app_command;
      n.arg  = item.argument;
      n.resp = '0;
      n.fcnt = '0;
      n.pcnt = '0;
      if (item.app_command) begin
        n.sel   = 1'b1;
        n.phase = sdc_pkg::PH_APP_READY;
        tx_v    = 1'b1;
      end else begin
        go_main = 1'b1;
      end
    end else begin
      unique case (st.phase)
        sdc_pkg::PH_APP_READY: begin
          tx_v = 1'b1;
          if (item.rx_byte == sdc_pkg::IDLE_BYTE) begin
            n.phase = sdc_pkg::PH_APP_FRAME;
            n.fcnt  = '0;
            tx_b    = sdc_pkg::app_frame_byte(3'd0);
          end
        end
        sdc_pkg::PH_APP_FRAME: begin
          n.fcnt = f;
          tx_v   = 1'b1;
          if (f < sdc_pkg::FRAME_LEN) begin
            tx_b = sdc_pkg::app_frame_byte(f);
          end else begin
            n.phase = sdc_pkg::PH_APP_POLL;
            n.pcnt  = 17'd1;
          end
        end
        sdc_pkg::PH_APP_POLL: begin
          if (poll_more) begin
            n.pcnt = st.pcnt + 17'd1;
            tx_v   = 1'b1;
          end else if (item.rx_byte > sdc_pkg::R1_OK_MAX) begin
            n.resp = {item.rx_byte, 8'h00};
            go_fin = 1'b1;
          end else begin
            go_main = 1'b1;
          end
        end
        sdc_pkg::PH_DESEL: begin
          n.sel   = 1'b1;
          n.phase = sdc_pkg::PH_READY;
          tx_v    = 1'b1;
        end
        sdc_pkg::PH_READY: begin
          if (item.rx_byte == sdc_pkg::IDLE_BYTE) go_frame = 1'b1;
          else tx_v = 1'b1;
        end
        sdc_pkg::PH_FRAME: begin
          n.fcnt = f;
          if (f < sdc_pkg::FRAME_LEN) begin
            tx_v = 1'b1;
            tx_b = sdc_pkg::frame_byte(f, st.cmd, st.app, st.arg);
          end else if (!st.app && st.cmd == sdc_pkg::CMD_STOP) begin
            n.phase = sdc_pkg::PH_STUFF;
            tx_v    = 1'b1;
          end else begin
            go_poll = 1'b1;
          end
        end
        sdc_pkg::PH_STUFF: go_poll = 1'b1;
        sdc_pkg::PH_POLL: begin
          if (poll_more) begin
            n.pcnt = st.pcnt + 17'd1;
            tx_v   = 1'b1;
          end else begin
            n.resp = {item.rx_byte, 8'h00};
            if (busy_cmd) begin
              n.phase = sdc_pkg::PH_BUSY;
              n.pcnt  = 17'd1;
              tx_v    = 1'b1;
            end else begin
              go_after = 1'b1;
            end
          end
        end
        sdc_pkg::PH_BUSY: begin
          if (busy_more) begin
            n.pcnt = st.pcnt + 17'd1;
            tx_v   = 1'b1;
          end else begin
            go_after = 1'b1;
          end
        end
        sdc_pkg::PH_R2: begin
          n.resp = {st.resp[15:8], st.resp[7:0] | item.rx_byte};
          go_fin = 1'b1;
        end
        default: n.phase = sdc_pkg::PH_IDLE;
      endcase
    end

    // Main command entry: plain CMD12 goes straight to its frame
    if (go_main) begin
      if (!n.app && n.cmd == sdc_pkg::CMD_STOP) begin
        go_frame = 1'b1;
      end else begin
        n.sel   = 1'b0;
        n.phase = sdc_pkg::PH_DESEL;
        tx_v    = 1'b1;
      end
    end

    if (go_frame) begin
      n.phase = sdc_pkg::PH_FRAME;
      n.fcnt  = '0;
      tx_v    = 1'b1;
      tx_b    = sdc_pkg::frame_byte(3'd0, n.cmd, n.app, n.arg);
    end

    if (go_poll) begin
      n.phase = sdc_pkg::PH_POLL;
      n.pcnt  = 17'd1;
      tx_v    = 1'b1;
    end

    // R2 byte for the status command, otherwise done
    if (go_after) begin
      if (n.cmd == sdc_pkg::CMD_STATUS) begin
        n.phase = sdc_pkg::PH_R2;
        tx_v    = 1'b1;
      end else begin
        go_fin = 1'b1;
      end
    end

    if (go_fin) begin
      n.phase = sdc_pkg::PH_IDLE;
      done    = 1'b1;
    end

    st_next             = n;
    res.tx_valid        = tx_v;
    res.tx_byte         = tx_b;
    res.chip_select_low = n.sel;
    res.done_res        = done;
    res.response        = done ? n.resp : '0;
  end

endmodule

### sv/sd_spi_command_engine.sv
// Top level of the SD SPI-mode command engine.
//
//  port | role   | carries
//  -----+--------+-------------------------------------------------------
//  req  | sink   | op, command_index, app_command, argument, rx_byte
//  rsp  | source | tx_valid, tx_byte, chip_select_low, done_res, response
//  cfg  | sink   | index, data (poll limits), always ready
//
// Each request is handled combinationally: the sequencer logic runs from the
// state register and the request payload straight into the result register.
// One request per cycle is taken while the result register is empty or drained.
// Synchronous active-high reset returns the sequencer to idle, deselected,
// with response polls 9 and busy polls 65536. A stalled rsp holds req off.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sd_spi_command_engine (
  input  logic   clk,
  input  logic   rst,
  sdc_req_if.sink   req,
  sdc_rsp_if.source rsp,
  sdc_cfg_if.sink   cfg
);

  sdc_pkg::state_t               st;
  sdc_pkg::state_t               st_next;
  sdc_pkg::item_t                item;
  sdc_pkg::result_t              res_next;
  sdc_pkg::result_t              res;
  logic                          res_valid;
  logic [sdc_pkg::RPollW-1:0]    rmax;
  logic [sdc_pkg::BPollW-1:0]    bmax;
  logic                          req_acc;
  logic                          start_acc;
  logic                          idle_rx_acc;
  logic                          quiet_res;
  logic                          done_shown;
  logic                          idle_now;

  assign item.op            = req.op;
  assign item.command_index = req.command_index;
  assign item.app_command   = req.app_command;
  assign item.argument      = req.argument;
  assign item.rx_byte       = req.rx_byte;

  assign req.ready = !res_valid || rsp.ready;
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  sdc_step u_step (
    .st      (st),
    .item    (item),
    .rmax    (rmax),
    .bmax    (bmax),
    .st_next (st_next),
    .res     (res_next)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: sdc_pkg::PH_IDLE, default: '0};
    end else if (req_acc) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_acc) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) res <= res_next;
  end

  assign rsp.valid           = res_valid;
  assign rsp.tx_valid        = res.tx_valid;
  assign rsp.tx_byte         = res.tx_byte;
  assign rsp.chip_select_low = res.chip_select_low;
  assign rsp.done_res        = res.done_res;
  assign rsp.response        = res.response;

  // Poll limits, clamped to their legal range on write
  always_ff @(posedge clk) begin
    if (rst) begin
      rmax <= sdc_pkg::RPOLL_RESET;
      bmax <= sdc_pkg::BPOLL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sdc_pkg::REG_RESP_POLLS: begin
          if (cfg.data[4:0] == '0) rmax <= sdc_pkg::RPOLL_MIN;
          else if (cfg.data[4:0] > sdc_pkg::RPOLL_MAX) rmax <= sdc_pkg::RPOLL_MAX;
          else rmax <= cfg.data[4:0];
        end
        sdc_pkg::REG_BUSY_POLLS: begin
          if (cfg.data == '0) bmax <= sdc_pkg::BPOLL_MIN;
          else if (cfg.data > sdc_pkg::BPOLL_MAX) bmax <= sdc_pkg::BPOLL_MAX;
          else bmax <= cfg.data;
        end
        default: ;
      endcase
    end
  end

  // Terms used by the checks below
  assign start_acc   = req_acc && req.op == sdc_pkg::OP_START;
  assign idle_rx_acc = req_acc && req.op == sdc_pkg::OP_RX && st.phase == sdc_pkg::PH_IDLE;
  assign quiet_res   = !res.tx_valid && !res.done_res;
  assign done_shown  = res_valid && res.done_res;
  assign idle_now    = st.phase == sdc_pkg::PH_IDLE;

  // A start never leaves the sequencer idle
  `SDC_ASSERT_NEXT(a_start_busy, clk, rst, start_acc, !idle_now)
  // A card byte while idle yields an empty result
  `SDC_ASSERT_NEXT(a_idle_byte, clk, rst, idle_rx_acc, res_valid && quiet_res)
  // A completion result is only shown with the sequencer idle
  `SDC_ASSERT_IMPL(a_done_idle, clk, rst, done_shown, idle_now && !res.tx_valid)

endmodule
